### hdl/trimmed_mean_adc_scaler_macros.svh
// assertion macros for the trimmed mean scaler
`ifndef TRIMMED_MEAN_ADC_SCALER_MACROS_SVH
`define TRIMMED_MEAN_ADC_SCALER_MACROS_SVH

// checked on every rising edge once reset has been released
`define TMAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define TMAS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hdl/tmas_pkg.sv
// shared types and constants of the trimmed mean scaler
`default_nettype none

package tmas_pkg;

  localparam int unsigned CntW         = 8;
  localparam int unsigned CntReset     = 20;
  localparam int unsigned MinCount     = 3;
  localparam int unsigned VoltW        = 9;
  localparam int unsigned PressW       = 16;
  localparam int unsigned VoltGain     = 320;
  localparam int unsigned PressGain    = 28928;
  localparam int unsigned PressGainW   = 15;
  localparam int unsigned PressOffset  = 1930;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take one sample into the burst
    logic load;      // form the trimmed sum, clear the burst
    logic div_step;  // one quotient bit
    logic mul;       // register the two scaling products
    logic emit;      // load the output register
  } tmas_cmd_t;

  // status from the datapath
  typedef struct packed {
    logic burst_done;  // the next accepted sample completes the burst
    logic div_last;    // the current step gives the last quotient bit
  } tmas_stat_t;

endpackage

`default_nettype wire

### hdl/tmas_ctrl.sv
// controller: sequences accept, divide, scale and output
`default_nettype none

module tmas_ctrl
  import tmas_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_valid_i,
  input  wire logic       m_ready_i,
  input  wire tmas_stat_t stat_i,
  output logic            s_ready_o,
  output logic            m_valid_o,
  output tmas_cmd_t       cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.burst_done) begin
            state_d = StLoad;
          end
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        // wait until the previous result has left the output register
        if (!m_valid_q || m_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.emit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == StIdle);
  assign m_valid_o = m_valid_q;

endmodule

`default_nettype wire

### hdl/tmas_dp.sv
// datapath: burst accumulation, serial divider and scaling
`default_nettype none

module tmas_dp
  import tmas_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [SAMPLE_WIDTH-1:0]   sample_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [CntW-1:0]           cfg_data_i,
  input  wire tmas_cmd_t                 cmd_i,
  output tmas_stat_t                     stat_o,
  output logic [SAMPLE_WIDTH-1:0]        average_o,
  output logic [VoltW-1:0]               volts_centi_o,
  output logic signed [PressW-1:0]       pressure_centi_o
);

  localparam int unsigned SumW   = SAMPLE_WIDTH + CntW;
  localparam int unsigned DivCntW = $clog2(SumW);
  localparam int unsigned VProdW = SAMPLE_WIDTH + VoltW;
  localparam int unsigned PProdW = SAMPLE_WIDTH + PressGainW;
  localparam int unsigned PDiffW = PProdW + 2;
  localparam logic [SAMPLE_WIDTH-1:0] FullScale = '1;
  localparam logic [PDiffW-1:0] OffsetScaled = PDiffW'(PressOffset) << SAMPLE_WIDTH;

  logic [CntW-1:0]         count_cfg_q;
  logic [SumW-1:0]         sum_q;
  logic [SAMPLE_WIDTH-1:0] max_q, min_q;
  logic [CntW-1:0]         taken_q;
  logic [CntW-1:0]         burst_len;
  logic [CntW:0]           taken_next;

  logic [SumW-1:0]         quo_q;
  logic [CntW-1:0]         rem_q;
  logic [CntW-1:0]         divisor_q;
  logic [DivCntW-1:0]      div_cnt_q;
  logic [CntW:0]           trial;
  logic [CntW:0]           trial_diff;
  logic                    qbit;

  logic [VProdW-1:0]       vprod_q;
  logic [PProdW-1:0]       pprod_q;
  logic signed [PDiffW-1:0] pdiff, pround;

  logic [SAMPLE_WIDTH-1:0] avg_q;
  logic [VoltW-1:0]        volts_q;
  logic signed [PressW-1:0] press_q;

  // burst length below three counts as three
  assign burst_len  = (count_cfg_q < CntW'(MinCount)) ? CntW'(MinCount) : count_cfg_q;
  assign taken_next = {1'b0, taken_q} + 1'b1;

  assign stat_o.burst_done = (taken_next >= {1'b0, burst_len});
  assign stat_o.div_last   = (div_cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_cfg_q <= CntW'(CntReset);
    end else if (cfg_we_i) begin
      count_cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= FullScale;
      taken_q <= '0;
    end else if (cmd_i.accept) begin
      sum_q   <= sum_q + SumW'(sample_i);
      max_q   <= (sample_i > max_q) ? sample_i : max_q;
      min_q   <= (sample_i < min_q) ? sample_i : min_q;
      taken_q <= taken_next[CntW-1:0];
    end else if (cmd_i.load) begin
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= FullScale;
      taken_q <= '0;
    end
  end

  // restoring division, one quotient bit a cycle, msb first
  assign trial      = {rem_q, quo_q[SumW-1]};
  assign trial_diff = trial - {1'b0, divisor_q};
  assign qbit       = (trial >= {1'b0, divisor_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q     <= sum_q - SumW'(max_q) - SumW'(min_q);
      rem_q     <= '0;
      divisor_q <= burst_len - CntW'(2);
      div_cnt_q <= DivCntW'(SumW - 1);
    end else if (cmd_i.div_step) begin
      rem_q     <= qbit ? trial_diff[CntW-1:0] : trial[CntW-1:0];
      quo_q     <= {quo_q[SumW-2:0], qbit};
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      vprod_q <= VProdW'(quo_q[SAMPLE_WIDTH-1:0]) * VProdW'(VoltGain);
      pprod_q <= PProdW'(quo_q[SAMPLE_WIDTH-1:0]) * PProdW'(PressGain);
    end
  end

  // truncate toward zero: bias negative values before the arithmetic shift
  assign pdiff  = $signed({2'b00, pprod_q}) - $signed(OffsetScaled);
  assign pround = pdiff[PDiffW-1] ? (pdiff + $signed(PDiffW'(FullScale))) : pdiff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      avg_q   <= quo_q[SAMPLE_WIDTH-1:0];
      volts_q <= vprod_q[SAMPLE_WIDTH +: VoltW];
      press_q <= pround[SAMPLE_WIDTH +: PressW];
    end
  end

  assign average_o        = avg_q;
  assign volts_centi_o    = volts_q;
  assign pressure_centi_o = press_q;

endmodule

`default_nettype wire

### hdl/trimmed_mean_adc_scaler.sv
// Trimmed mean ("olympic") filter with voltage and pressure scaling. Each sample is
// accepted in one cycle while a burst fills. The sample that completes a burst of
// sample_count samples starts the result path: the load step drops the largest and
// smallest sample, the bit-serial divider forms the mean, the scaling multipliers are
// registered and the output register is loaded, and no new sample is taken until that
// last step is done. The output register holds a finished result while the next burst
// fills; the final step waits only if the previous result has still not been taken. A
// sample_count below three acts as three.
`default_nettype none

`include "trimmed_mean_adc_scaler_macros.svh"

module trimmed_mean_adc_scaler
  import tmas_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // sample
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // average, volts_centi, pressure_centi
  output logic [((SAMPLE_WIDTH+VoltW+PressW+7)/8)*8-1:0] m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CntW-1:0]         cfg_data_i
);

  localparam int unsigned OutTdW = ((SAMPLE_WIDTH + VoltW + PressW + 7) / 8) * 8;

  tmas_cmd_t                cmd;
  tmas_stat_t               stat;
  logic [SAMPLE_WIDTH-1:0]  average;
  logic [VoltW-1:0]         volts_centi;
  logic signed [PressW-1:0] pressure_centi;

  tmas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  tmas_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_i         (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .cfg_we_i         (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .average_o        (average),
    .volts_centi_o    (volts_centi),
    .pressure_centi_o (pressure_centi)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = OutTdW'({pressure_centi, volts_centi, average});

  `TMAS_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
  `TMAS_ASSERT(a_busy_no_accept, (cmd.load || cmd.div_step || cmd.mul) |-> !s_axis_tready,
    "sample accepted while a result is being computed")
  `TMAS_ASSERT(a_valid_from_emit, $rose(m_axis_tvalid) |-> $past(cmd.emit),
    "result shown without a completed burst")

endmodule

`default_nettype wire

### tb/sv/tmas_checker.sv
`timescale 1ns / 1ps
// checker for the trimmed mean scaler: burst predictor and result compare
module tmas_checker
  import tmas_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 12
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]               s_tdata_i,  // sample
  input  logic                                            s_tvalid_i,
  input  logic                                            s_tready_i,
  // average, volts_centi, pressure_centi
  input  logic [((SAMPLE_WIDTH+VoltW+PressW+7)/8)*8-1:0]  m_tdata_i,
  input  logic                                            m_tvalid_i,
  input  logic                                            m_tready_i,
  input  logic                                            cfg_valid_i,
  input  logic                                            cfg_ready_i,
  input  logic [CntW-1:0]                                 cfg_data_i,
  output int unsigned                                     fail_count_o,
  output int unsigned                                     pending_o,
  output int unsigned                                     results_o
);

  localparam int unsigned FullScale = (1 << SAMPLE_WIDTH) - 1;
  localparam longint      PressGainL = PressGain;
  localparam longint      PressBias  = longint'(PressOffset) << SAMPLE_WIDTH;
  localparam longint      PressDiv   = longint'(1) << SAMPLE_WIDTH;

  typedef struct packed {
    logic signed [PressW-1:0] pressure_centi;
    logic [VoltW-1:0]         volts_centi;
    logic [SAMPLE_WIDTH-1:0]  average;
  } burst_result_t;

  burst_result_t   scaled_due[$];
  logic [CntW-1:0] burst_length;
  int unsigned     burst_sum;
  int unsigned     burst_max;
  int unsigned     burst_min;
  int unsigned     burst_taken;

  function automatic void restart_burst();
    burst_sum   = 0;
    burst_max   = 0;
    burst_min   = FullScale;
    burst_taken = 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    burst_result_t seen;
    burst_result_t want;
    burst_result_t fresh;
    int unsigned   sample;
    int unsigned   span;
    int unsigned   avg;
    longint        avg_l;
    longint        press;
    if (!rst_ni) begin
      scaled_due.delete();
      burst_length = CntReset;
      restart_burst();
      fail_count_o = 0;
      results_o    = 0;
    end else begin
      // compare first: a result leaving now is always older than one queued now
      if (m_tvalid_i && m_tready_i) begin
        seen = m_tdata_i[$bits(burst_result_t)-1:0];
        results_o++;
        if (scaled_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, got avg %0d volts %0d press %0d",
                   $time, seen.average, seen.volts_centi, $signed(seen.pressure_centi));
        end else begin
          want = scaled_due.pop_front();
          if (seen !== want) begin
            fail_count_o++;
            $display("%0t: result mismatch, expected avg %0d volts %0d press %0d, got %0d %0d %0d",
                     $time, want.average, want.volts_centi, $signed(want.pressure_centi),
                     seen.average, seen.volts_centi, $signed(seen.pressure_centi));
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        sample = s_tdata_i[SAMPLE_WIDTH-1:0];
        span   = (burst_length < MinCount) ? MinCount : burst_length;
        burst_sum += sample;
        if (sample > burst_max) burst_max = sample;
        if (sample < burst_min) burst_min = sample;
        burst_taken = (burst_taken + 1) & 8'hFF;
        if (burst_taken >= span) begin
          // both extremes are always inside the sum
          avg   = ((burst_sum - burst_max - burst_min) / (span - 2)) & FullScale;
          avg_l = avg;
          press = (avg_l * PressGainL - PressBias) / PressDiv;
          fresh.average        = SAMPLE_WIDTH'(avg);
          fresh.volts_centi    = VoltW'((avg * VoltGain) >> SAMPLE_WIDTH);
          fresh.pressure_centi = PressW'(press);
          scaled_due.push_back(fresh);
          restart_burst();
        end
      end

      if (cfg_valid_i && cfg_ready_i) burst_length = cfg_data_i;
    end
    pending_o = scaled_due.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench top for the trimmed mean scaler: clock, reset, stimulus and verdict
module tb;
  import tmas_pkg::*;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned SDataW    = ((SampleW + 7) / 8) * 8;
  localparam int unsigned MDataW    = ((SampleW + VoltW + PressW + 7) / 8) * 8;
  localparam int unsigned FullScale = (1 << SampleW) - 1;
  localparam int unsigned DrainGap  = 30;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseLen [NumPhases] = '{60, 40, 255, 40, 30, 36};
  localparam logic [CntW-1:0] PhaseCount [NumPhases] = '{8'd3, 8'd20, 8'd255, 8'd5, 8'd4, 8'd12};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [SDataW-1:0] s_tdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [MDataW-1:0] m_tdata;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CntW-1:0]   cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned samples_sent = 0;
  int unsigned lengths_written = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  always #5 clk = ~clk;

  trimmed_mean_adc_scaler #(
    .SAMPLE_WIDTH(SampleW)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tdata (s_tdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  tmas_checker #(
    .SAMPLE_WIDTH(SampleW)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tdata_i   (s_tdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .m_tdata_i   (m_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results_seen)
  );

  // result side back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic push_sample(input logic [SampleW-1:0] sample);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= SDataW'(sample);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  // hold the sender off until every result is out, then let the divider settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainGap) @(posedge clk);
  endtask

  task automatic write_length(input logic [CntW-1:0] length);
    cfg_valid <= 1'b1;
    cfg_data  <= length;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lengths_written++;
  endtask

  initial begin
    int unsigned        level;
    int unsigned        pick;
    int                 near;
    logic [SampleW-1:0] sample;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset burst length, then lowered part way through the burst
    push_sample(12'hFFF); push_sample(12'h000); push_sample(12'h001); push_sample(12'h800);
    drain();
    write_length(8'd3);
    push_sample(12'd100);

    // shortest bursts at the extremes and with alternating bits
    push_sample(12'h000); push_sample(12'h000); push_sample(12'h000);
    push_sample(12'hFFF); push_sample(12'hFFF); push_sample(12'hFFF);
    push_sample(12'hAAA); push_sample(12'h555); push_sample(12'hFFF);

    // lengths below three behave as three
    drain();
    write_length(8'd0);
    push_sample(12'd7); push_sample(12'd9); push_sample(12'd8);
    drain();
    write_length(8'd1);
    push_sample(12'hFFF); push_sample(12'hFFF); push_sample(12'h000);
    drain();
    write_length(8'd2);
    push_sample(12'd1); push_sample(12'd2); push_sample(12'd3);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      write_length(PhaseCount[ph]);
      level = $urandom_range(0, FullScale);
      // a noisy level in four of ten samples, a rail hit in two, the rest anywhere
      for (int i = 0; i < PhaseLen[ph]; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          sample = '0;
        end else if (pick == 1) begin
          sample = '1;
        end else if (pick < 6) begin
          near = int'(level) + int'($urandom_range(0, 64)) - 32;
          sample = (near < 0) ? '0 : (near > int'(FullScale)) ? '1 : SampleW'(near);
        end else begin
          sample = SampleW'($urandom);
        end
        push_sample(sample);
      end
    end
    drain();

    $display("covered %0d samples and %0d burst results over %0d burst length writes",
             samples_sent, results_seen, lengths_written);
    $display("lengths 0 to 255 incl. clamped and mid-burst changes, with idle and stall phases");
    if (pending != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timed out", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/tmas_pkg.sv
hdl/tmas_ctrl.sv
hdl/tmas_dp.sv
hdl/trimmed_mean_adc_scaler.sv
tb/sv/tmas_checker.sv
tb/sv/tb.sv
